>>> hdl/ccp_pkg.sv
// Shared types and constants for the three-point circle fit.
// Holds word widths, the channel word structs and the sideband structs
// that travel with the divider and square root pipelines. No dependencies.
package ccp_pkg;

  // Coordinate width of one input point
  localparam int COORD_BITS = 12;

  // Intermediate widths, all derived from the coordinate width
  localparam int RW   = 2 * COORD_BITS + 1;  // x*x+y*y and cross differences
  localparam int DFW  = COORD_BITS + 1;      // coordinate differences
  localparam int DETW = 2 * COORD_BITS + 2;  // main determinant
  localparam int RDW  = 2 * COORD_BITS + 2;  // differences of squared norms
  localparam int PRW  = 4 * COORD_BITS + 2;  // norm times cross term
  localparam int PBW  = 3 * COORD_BITS + 3;  // norm difference times coordinate difference
  localparam int NUMW = 4 * COORD_BITS + 4;  // determinant numerators

  // Quotient widths: B and C beyond QT bits force a saturated radius
  localparam int QT   = (COORD_BITS + 3 > 19) ? COORD_BITS + 3 : 19;
  localparam int QA   = 2 * QT + 2;
  localparam int CW   = (NUMW > DETW + QA) ? NUMW : DETW + QA;
  localparam int SQW  = 2 * QT;
  localparam int RSW  = 2 * QT + 4;

  // Result widths
  localparam int OUT_W    = 16;
  localparam int ROOT_W   = 16;
  localparam int RAD_IN_W = 2 * ROOT_W;

  // Divider lanes
  localparam int LANE_A = 0;
  localparam int LANE_B = 1;
  localparam int LANE_C = 2;

  // Clip values
  localparam logic signed [OUT_W-1:0] CENTER_MAX = 16'sh7fff;
  localparam logic signed [OUT_W-1:0] CENTER_MIN = 16'sh8000;
  localparam logic [ROOT_W-1:0]       RAD_MAX    = 16'hffff;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_a_x;
    logic signed [COORD_BITS-1:0] point_a_y;
    logic signed [COORD_BITS-1:0] point_b_x;
    logic signed [COORD_BITS-1:0] point_b_y;
    logic signed [COORD_BITS-1:0] point_c_x;
    logic signed [COORD_BITS-1:0] point_c_y;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic [ROOT_W-1:0]       circle_radius;
    logic                    collinear_flag;
    logic                    saturated_flag;
  } out_t;

  // Travels with the divider: quotient signs and range overflow per lane
  typedef struct packed {
    logic       col;
    logic [2:0] neg;
    logic [2:0] ovf;
  } div_side_t;

  // Travels with the square root: finished centre and radius overrides
  typedef struct packed {
    logic                    col;
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
    logic                    sat;
    logic                    rad_sat;
    logic                    rad_zero;
  } sq_side_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] val;
    logic                    sat;
  } clip_t;

endpackage

>>> hdl/ccp_div.sv
// Three-lane pipelined restoring divider sharing one divisor.
// One quotient bit per stage for each lane; sideband travels alongside.
// Depends on ccp_pkg.
module ccp_div
  import ccp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][NUMW-1:0] num,
  input  logic [DETW-1:0]      den,
  input  div_side_t            side_in,
  output logic                 out_valid,
  output logic [2:0][QA-1:0]   quot,
  output div_side_t            side_out
);

  logic [QA:1]             vld;
  logic [2:0][CW-1:0]      rem [1:QA];
  logic [2:0][QA-1:0]      quo [1:QA];
  logic [DETW-1:0]         dv  [1:QA];
  div_side_t               sd  [1:QA];

  for (genvar s = 0; s < QA; s++) begin : g_stage
    localparam int SH = QA - 1 - s;
    logic               src_vld;
    logic [2:0][CW-1:0] src_rem;
    logic [2:0][QA-1:0] src_quo;
    logic [DETW-1:0]    src_dv;
    div_side_t          src_sd;
    logic [CW-1:0]      dsh;
    logic [2:0]         fit;

    // Pick the stage input: the ports for the first stage
    if (s == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_rem = {CW'(num[2]), CW'(num[1]), CW'(num[0])};
      assign src_quo = '0;
      assign src_dv  = den;
      assign src_sd  = side_in;
    end else begin : g_next
      assign src_vld = vld[s];
      assign src_rem = rem[s];
      assign src_quo = quo[s];
      assign src_dv  = dv[s];
      assign src_sd  = sd[s];
    end

    // Trial subtract of the shifted divisor
    assign dsh = CW'(src_dv) << SH;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        fit[i] = src_rem[i] >= dsh;
      end
    end

    // Advance valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= src_vld;
      end
    end

    // Advance remainder, quotient and sideband
    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          rem[s+1][i] <= fit[i] ? src_rem[i] - dsh : src_rem[i];
          quo[s+1][i] <= {src_quo[i][QA-2:0], fit[i]};
        end
        dv[s+1] <= src_dv;
        sd[s+1] <= src_sd;
      end
    end
  end

  assign out_valid = vld[QA];
  assign quot      = quo[QA];
  assign side_out  = sd[QA];

endmodule

>>> hdl/ccp_sqrt.sv
// Pipelined integer square root of a 32-bit radicand, one root bit per stage.
// Keeps the running remainder so each stage is one add and compare.
// Depends on ccp_pkg.
module ccp_sqrt
  import ccp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [RAD_IN_W-1:0] value,
  input  sq_side_t            side_in,
  output logic                out_valid,
  output logic [ROOT_W-1:0]   root,
  output sq_side_t            side_out
);

  localparam int SRW = RAD_IN_W + 2;

  logic [ROOT_W:1]     vld;
  logic [SRW-1:0]      rem [1:ROOT_W];
  logic [ROOT_W-1:0]   rt  [1:ROOT_W];
  sq_side_t            sd  [1:ROOT_W];

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int BP = ROOT_W - 1 - s;
    logic              src_vld;
    logic [SRW-1:0]    src_rem;
    logic [ROOT_W-1:0] src_rt;
    sq_side_t          src_sd;
    logic [SRW-1:0]    trial;
    logic              fit;

    // Pick the stage input: the ports for the first stage
    if (s == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_rem = SRW'(value);
      assign src_rt  = '0;
      assign src_sd  = side_in;
    end else begin : g_next
      assign src_vld = vld[s];
      assign src_rem = rem[s];
      assign src_rt  = rt[s];
      assign src_sd  = sd[s];
    end

    // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
    assign trial = (SRW'(src_rt) << (BP + 1)) + (SRW'(1) << (2 * BP));
    assign fit   = src_rem >= trial;

    // Advance valid
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= src_vld;
      end
    end

    // Advance remainder, root and sideband
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= fit ? src_rem - trial : src_rem;
        rt[s+1]  <= src_rt | (ROOT_W'(fit) << BP);
        sd[s+1]  <= src_sd;
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = rt[ROOT_W];
  assign side_out  = sd[ROOT_W];

endmodule

>>> hdl/circle_from_three_points_unit.sv
// Circle through three integer points: centre, radius and status flags.
// Depends on ccp_pkg, ccp_div and ccp_sqrt.
//
// Usage:
//   The point channel (point_valid, point_stall, point) takes one word of
//   three points; the circle channel (circle_valid, circle_stall, circle)
//   returns one word per point word, in order.
//   The pipeline has five stages of products and determinant sums,
//   40 stages of the shared-divisor divider (one quotient bit per stage),
//   two stages for the quarter squares and radicand, 16 stages of the
//   square root (one root bit per stage) and the output register.
//   Throughput is one word per cycle while the receiver takes results.
//   A stall on the circle side while circle_valid is high freezes the whole
//   pipeline in place; the point side then sees point_stall and nothing is lost or repeated.
//   Reset (rst, synchronous) clears every valid bit; no word is in flight
//   afterwards and no clearing pass is needed.
//   Collinear points give centre 0,0, radius 0 and collinear_flag.
//   Out-of-range centre or oversized radius is clipped and sets saturated_flag.
module circle_from_three_points_unit
  import ccp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic point_valid,
  output logic point_stall,
  input  in_t  point,
  output logic circle_valid,
  input  logic circle_stall,
  output out_t circle
);

  // Truncate B/2 toward zero and clip to 16 bits
  function automatic clip_t center_of(input logic [QT-1:0] q, input logic neg,
                                      input logic ovf);
    logic [QT-2:0] mag;
    clip_t         r;
    mag   = q[QT-1:1];
    r.sat = ovf || (neg ? (mag > (QT-1)'(32768)) : (mag > (QT-1)'(32767)));
    if (r.sat) begin
      r.val = neg ? CENTER_MIN : CENTER_MAX;
    end else if (neg) begin
      r.val = $signed(16'd0 - mag[OUT_W-1:0]);
    end else begin
      r.val = $signed(mag[OUT_W-1:0]);
    end
    return r;
  endfunction

  logic adv;

  // Pipeline moves whenever the output register can take a word
  assign adv         = !circle_valid || !circle_stall;
  assign point_stall = !adv;

  logic signed [COORD_BITS-1:0] px [3];
  logic signed [COORD_BITS-1:0] py [3];

  assign px[0] = point.point_a_x;
  assign py[0] = point.point_a_y;
  assign px[1] = point.point_b_x;
  assign py[1] = point.point_b_y;
  assign px[2] = point.point_c_x;
  assign py[2] = point.point_c_y;

  // Stage 1: squared norms, cross terms, differences
  logic                  v1;
  logic signed [RW-1:0]  s1_ss [3];
  logic signed [RW-1:0]  s1_k  [3];
  logic signed [DFW-1:0] s1_dx2, s1_dy2, s1_dx3, s1_dy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= point_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_ss[i] <= RW'(px[i]) * RW'(px[i]) + RW'(py[i]) * RW'(py[i]);
      end
      s1_k[0] <= RW'(px[1]) * RW'(py[2]) - RW'(px[2]) * RW'(py[1]);
      s1_k[1] <= RW'(px[0]) * RW'(py[2]) - RW'(px[2]) * RW'(py[0]);
      s1_k[2] <= RW'(px[0]) * RW'(py[1]) - RW'(px[1]) * RW'(py[0]);
      s1_dx2  <= DFW'(px[1]) - DFW'(px[0]);
      s1_dy2  <= DFW'(py[1]) - DFW'(py[0]);
      s1_dx3  <= DFW'(px[2]) - DFW'(px[0]);
      s1_dy3  <= DFW'(py[2]) - DFW'(py[0]);
    end
  end

  // Stage 2: main determinant and norm differences
  logic                   v2;
  logic signed [DETW-1:0] s2_det;
  logic signed [RDW-1:0]  s2_rd2, s2_rd3;
  logic signed [RW-1:0]   s2_ss [3];
  logic signed [RW-1:0]   s2_k  [3];
  logic signed [DFW-1:0]  s2_dx2, s2_dy2, s2_dx3, s2_dy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_det <= DETW'(s1_dx2) * DETW'(s1_dy3) - DETW'(s1_dx3) * DETW'(s1_dy2);
      s2_rd2 <= RDW'(s1_ss[0]) - RDW'(s1_ss[1]);
      s2_rd3 <= RDW'(s1_ss[0]) - RDW'(s1_ss[2]);
      s2_ss  <= s1_ss;
      s2_k   <= s1_k;
      s2_dx2 <= s1_dx2;
      s2_dy2 <= s1_dy2;
      s2_dx3 <= s1_dx3;
      s2_dy3 <= s1_dy3;
    end
  end

  // Stage 3: numerator products
  logic                   v3;
  logic signed [PRW-1:0]  s3_m [3];
  logic signed [PBW-1:0]  s3_pb1, s3_pb2, s3_pc1, s3_pc2;
  logic signed [DETW-1:0] s3_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s3_m[i] <= PRW'(s2_ss[i]) * PRW'(s2_k[i]);
      end
      s3_pb1 <= PBW'(s2_rd2) * PBW'(s2_dy3);
      s3_pb2 <= PBW'(s2_rd3) * PBW'(s2_dy2);
      s3_pc1 <= PBW'(s2_dx2) * PBW'(s2_rd3);
      s3_pc2 <= PBW'(s2_dx3) * PBW'(s2_rd2);
      s3_det <= s2_det;
    end
  end

  // Stage 4: sum the determinant numerators
  logic                   v4;
  logic signed [NUMW-1:0] s4_num [3];
  logic signed [DETW-1:0] s4_det;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_num[LANE_A] <= NUMW'(s3_m[1]) - NUMW'(s3_m[0]) - NUMW'(s3_m[2]);
      s4_num[LANE_B] <= NUMW'(s3_pb2) - NUMW'(s3_pb1);
      s4_num[LANE_C] <= NUMW'(s3_pc2) - NUMW'(s3_pc1);
      s4_det         <= s3_det;
    end
  end

  // Stage 5: magnitudes, quotient signs, range checks
  logic [2:0][NUMW-1:0] mag;
  logic [DETW-1:0]      dmag;
  div_side_t            side5;

  always_comb begin
    dmag = s4_det[DETW-1] ? DETW'(-s4_det) : DETW'(s4_det);
    for (int i = 0; i < 3; i++) begin
      mag[i]       = s4_num[i][NUMW-1] ? NUMW'(-s4_num[i]) : NUMW'(s4_num[i]);
      side5.neg[i] = s4_num[i][NUMW-1] ^ s4_det[DETW-1];
    end
    side5.col         = (s4_det == '0);
    side5.ovf[LANE_A] = CW'(mag[LANE_A]) >= (CW'(dmag) << QA);
    side5.ovf[LANE_B] = CW'(mag[LANE_B]) >= (CW'(dmag) << QT);
    side5.ovf[LANE_C] = CW'(mag[LANE_C]) >= (CW'(dmag) << QT);
  end

  logic                 v5;
  logic [2:0][NUMW-1:0] s5_num;
  logic [DETW-1:0]      s5_den;
  div_side_t            s5_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_num  <= mag;
      s5_den  <= dmag;
      s5_side <= side5;
    end
  end

  // Divide all three numerators by the determinant
  logic               d_valid;
  logic [2:0][QA-1:0] d_quot;
  div_side_t          d_side;

  ccp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v5),
    .num       (s5_num),
    .den       (s5_den),
    .side_in   (s5_side),
    .out_valid (d_valid),
    .quot      (d_quot),
    .side_out  (d_side)
  );

  // Post stage 1: centre, quarter squares, signed A
  logic [QT-1:0]       qb, qc;
  logic [SQW-1:0]      sqb, sqc;
  logic signed [QA:0]  aval;
  clip_t               cxc, cyc;
  sq_side_t            side_p1;

  always_comb begin
    qb   = d_quot[LANE_B][QT-1:0];
    qc   = d_quot[LANE_C][QT-1:0];
    cxc  = center_of(qb, d_side.neg[LANE_B], d_side.ovf[LANE_B]);
    cyc  = center_of(qc, d_side.neg[LANE_C], d_side.ovf[LANE_C]);
    sqb  = SQW'(qb) * SQW'(qb);
    sqc  = SQW'(qc) * SQW'(qc);
    aval = d_side.neg[LANE_A] ? -$signed({1'b0, d_quot[LANE_A]})
                              : $signed({1'b0, d_quot[LANE_A]});
    side_p1.col      = d_side.col;
    side_p1.cx       = cxc.val;
    side_p1.cy       = cyc.val;
    side_p1.sat      = cxc.sat | cyc.sat;
    // A large centre forces a huge radius; A out of range decides by sign
    side_p1.rad_sat  = d_side.ovf[LANE_B] | d_side.ovf[LANE_C] |
                       (d_side.ovf[LANE_A] & d_side.neg[LANE_A]);
    side_p1.rad_zero = d_side.ovf[LANE_A] & !d_side.neg[LANE_A];
  end

  logic               pv1;
  logic [SQW-1:0]     p1_bq, p1_cq;
  logic signed [QA:0] p1_a;
  sq_side_t           p1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv1 <= 1'b0;
    end else if (adv) begin
      pv1 <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_bq   <= sqb >> 2;
      p1_cq   <= sqc >> 2;
      p1_a    <= aval;
      p1_side <= side_p1;
    end
  end

  // Post stage 2: radicand and its range
  logic signed [RSW-1:0] rsq;
  logic                  rneg, rbig;
  sq_side_t              side_p2;

  always_comb begin
    rsq  = $signed(RSW'(p1_bq)) + $signed(RSW'(p1_cq)) - RSW'(p1_a);
    rneg = rsq[RSW-1];
    rbig = |rsq[RSW-2:RAD_IN_W];
    side_p2          = p1_side;
    side_p2.rad_sat  = p1_side.rad_sat | (!rneg & rbig);
    side_p2.rad_zero = p1_side.rad_zero | rneg;
  end

  logic                pv2;
  logic [RAD_IN_W-1:0] p2_val;
  sq_side_t            p2_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv2 <= 1'b0;
    end else if (adv) begin
      pv2 <= pv1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_val  <= rsq[RAD_IN_W-1:0];
      p2_side <= side_p2;
    end
  end

  // Square root of the radicand
  logic              r_valid;
  logic [ROOT_W-1:0] r_root;
  sq_side_t          r_side;

  ccp_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pv2),
    .value     (p2_val),
    .side_in   (p2_side),
    .out_valid (r_valid),
    .root      (r_root),
    .side_out  (r_side)
  );

  // Assemble the result word
  out_t circle_next;

  always_comb begin
    circle_next = '0;
    if (r_side.col) begin
      circle_next.collinear_flag = 1'b1;
    end else begin
      circle_next.center_x = r_side.cx;
      circle_next.center_y = r_side.cy;
      if (r_side.rad_sat) begin
        circle_next.circle_radius = RAD_MAX;
      end else if (r_side.rad_zero) begin
        circle_next.circle_radius = '0;
      end else begin
        circle_next.circle_radius = r_root;
      end
      circle_next.saturated_flag = r_side.sat | r_side.rad_sat;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      circle_valid <= 1'b0;
    end else if (adv) begin
      circle_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      circle <= circle_next;
    end
  end

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for circle_from_three_points_unit.
// Depends on ccp_pkg and the unit. It predicts each circle word with exact wide integer math
// and drives directed words, then random bursts, against random stalls on the circle side.
module tb_top;
  import ccp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  // Holds expected circle words and compares them with what the block returns
  class circle_scoreboard;
    out_t pending[$];
    int   errors;

    function new();
      pending = {};
      errors  = 0;
    endfunction

    static function logic signed [OUT_W-1:0] clip16(wide_t v, ref logic sat);
      if (v > 32767) begin
        sat = 1'b1;
        return CENTER_MAX;
      end
      if (v < -32768) begin
        sat = 1'b1;
        return CENTER_MIN;
      end
      return v[OUT_W-1:0];
    endfunction

    static function logic [ROOT_W-1:0] root_floor(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] t;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r[ROOT_W-1:0];
    endfunction

    // Fit the circle through three points with exact determinants
    static function out_t fit_circle(in_t p);
      wide_t x1, y1, x2, y2, x3, y3, r1, r2, r3, det;
      wide_t da, db, dc, qa, qb, qc, qsb, qsc, rsq, mb, mc;
      logic  sat;
      out_t  o;
      x1 = $signed(p.point_a_x);
      y1 = $signed(p.point_a_y);
      x2 = $signed(p.point_b_x);
      y2 = $signed(p.point_b_y);
      x3 = $signed(p.point_c_x);
      y3 = $signed(p.point_c_y);
      o = '0;
      sat = 1'b0;
      r1 = -(x1 * x1 + y1 * y1);
      r2 = -(x2 * x2 + y2 * y2);
      r3 = -(x3 * x3 + y3 * y3);
      det = (x2 - x1) * (y3 - y1) - (x3 - x1) * (y2 - y1);
      if (det == 0) begin
        o.collinear_flag = 1'b1;
        return o;
      end
      da = r1 * (x2 * y3 - x3 * y2) - r2 * (x1 * y3 - x3 * y1) + r3 * (x1 * y2 - x2 * y1);
      db = -((r2 - r1) * (y3 - y1) - (r3 - r1) * (y2 - y1));
      dc = -((x2 - x1) * (r3 - r1) - (x3 - x1) * (r2 - r1));
      qa = da / det;
      qb = db / det;
      qc = dc / det;
      o.center_x = clip16(qb / 2, sat);
      o.center_y = clip16(qc / 2, sat);
      mb = (qb < 0) ? -qb : qb;
      mc = (qc < 0) ? -qc : qc;
      qsb = (mb * mb) >>> 2;
      qsc = (mc * mc) >>> 2;
      rsq = qsb + qsc - qa;
      if (rsq < 0) begin
        o.circle_radius = '0;
      end else if (rsq >= (wide_t'(1) <<< 32)) begin
        o.circle_radius = RAD_MAX;
        sat = 1'b1;
      end else begin
        o.circle_radius = root_floor(rsq[63:0]);
      end
      o.saturated_flag = sat;
      return o;
    endfunction

    function void note_points(in_t p);
      pending = {pending, fit_circle(p)};
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_circle(out_t got);
      out_t exp;
      if (pending.size() == 0) begin
        report($sformatf("unexpected circle word %h", got));
        return;
      end
      exp = pending.pop_front();
      if (got.center_x !== exp.center_x)
        report($sformatf("center_x got %0d exp %0d", got.center_x, exp.center_x));
      if (got.center_y !== exp.center_y)
        report($sformatf("center_y got %0d exp %0d", got.center_y, exp.center_y));
      if (got.circle_radius !== exp.circle_radius)
        report($sformatf("circle_radius got %0d exp %0d",
                         got.circle_radius, exp.circle_radius));
      if (got.collinear_flag !== exp.collinear_flag)
        report($sformatf("collinear_flag got %b exp %b",
                         got.collinear_flag, exp.collinear_flag));
      if (got.saturated_flag !== exp.saturated_flag)
        report($sformatf("saturated_flag got %b exp %b",
                         got.saturated_flag, exp.saturated_flag));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  logic point_stall;
  in_t  point = '0;
  logic circle_valid;
  logic circle_stall = 1'b0;
  out_t circle;
  logic point_taken = 1'b0;
  int   stall_mode = 0;
  circle_scoreboard board = new();

  always #5 clk = ~clk;

  circle_from_three_points_unit dut (
    .clk(clk),
    .rst(rst),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point(point),
    .circle_valid(circle_valid),
    .circle_stall(circle_stall),
    .circle(circle)
  );

  // Note accepted point words and check accepted circle words
  always @(posedge clk) begin
    point_taken <= point_valid && !point_stall && !rst;
    if (!rst && point_valid && !point_stall) board.note_points(point);
    if (!rst && circle_valid && !circle_stall) board.check_circle(circle);
  end

  // Stall the circle side in phases: none, light, heavy
  always @(negedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: begin
        circle_stall <= 1'b0;
      end
      1: begin
        circle_stall <= ($urandom_range(0, 99) < 25);
      end
      default: begin
        circle_stall <= ($urandom_range(0, 99) < 75);
      end
    endcase
  end

  function automatic logic signed [COORD_BITS-1:0] to_coord(int v);
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic in_t make_word(int ax, int ay, int bx, int by, int cx, int cy);
    in_t w;
    w.point_a_x = to_coord(ax);
    w.point_a_y = to_coord(ay);
    w.point_b_x = to_coord(bx);
    w.point_b_y = to_coord(by);
    w.point_c_x = to_coord(cx);
    w.point_c_y = to_coord(cy);
    return w;
  endfunction

  function automatic int rnd_coord();
    return $urandom_range(0, 4095) - 2048;
  endfunction

  function automatic int rnd_off(int span);
    return $urandom_range(0, 2 * span) - span;
  endfunction

  // Drive one word and hold it until taken; call at a falling edge
  task send_word(in_t w);
    point <= w;
    point_valid <= 1'b1;
    do @(negedge clk); while (!point_taken);
  endtask

  // Drop valid for a random gap, sometimes none
  task maybe_gap();
    int n;
    if ($urandom_range(0, 3) != 0) return;
    n = $urandom_range(1, 12);
    point_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic in_t random_word();
    int ax, ay, dx, dy, k, pick;
    pick = $urandom_range(0, 99);
    ax = rnd_coord();
    ay = rnd_coord();
    if (pick < 40) begin
      return make_word(ax, ay, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
    end else if (pick < 65) begin
      // small triangle anywhere
      return make_word(ax, ay, ax + rnd_off(16), ay + rnd_off(16),
                       ax + rnd_off(16), ay + rnd_off(16));
    end else if (pick < 78) begin
      // points on one line
      dx = rnd_off(64);
      dy = rnd_off(64);
      k = $urandom_range(0, 4) - 2;
      ax = ax / 2;
      ay = ay / 2;
      return make_word(ax, ay, ax + dx, ay + dy, ax + k * dx, ay + k * dy);
    end else if (pick < 92) begin
      // nearly on one line: huge circles
      dx = rnd_off(600);
      dy = rnd_off(600);
      ax = ax / 3;
      ay = ay / 3;
      return make_word(ax, ay, ax + dx, ay + dy,
                       ax + 2 * dx + rnd_off(1), ay + 2 * dy + rnd_off(1));
    end else begin
      // duplicated points
      dx = rnd_coord();
      dy = rnd_coord();
      return make_word(ax, ay, ax, ay, dx, dy);
    end
  endfunction

  in_t directed[$];

  initial begin
    int burst;
    directed = {
      make_word(-2048, -2048, 2047, -2048, -2048, 2047),
      make_word(2047, 2047, -2048, 2047, 2047, -2048),
      make_word(0, 0, 1, 0, 0, 1),
      make_word(0, 0, 0, 0, 0, 0),
      make_word(-2048, -2048, -2048, -2048, -2048, -2048),
      make_word(0, 0, 5, 5, 10, 10),
      make_word(-2048, -2048, 0, 0, 2047, 2047),
      make_word(-2048, -2048, 2047, 2047, 2047, 2046),
      make_word(-2048, 0, 2047, 0, 0, 1),
      make_word(0, 0, 2047, 0, 0, 2047),
      make_word(-1366, 1365, 1365, -1366, -1366, -1366),
      make_word(1, 1, -1, -1, 1, -1),
      make_word(0, 0, 2047, 1, -2048, -1),
      make_word(-2048, 2047, 2047, -2048, 0, 1),
      make_word(100, 100, 101, 100, 100, 101),
      make_word(-1, -1, 0, 0, 1, 2),
      make_word(2047, 0, 0, 2047, -2048, 0),
      make_word(3, 4, -3, 4, 3, -4),
      make_word(-2048, 2047, -2047, 2047, -2048, 2046),
      make_word(1000, -2048, 1001, 2047, 1002, -2048)
    };
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (directed[i]) begin
      send_word(directed[i]);
      maybe_gap();
    end
    for (int n = 0; n < 1450; n += burst) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst; j++) send_word(random_word());
      point_valid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> circle_from_three_points_unit.f
hdl/ccp_pkg.sv
hdl/ccp_div.sv
hdl/ccp_sqrt.sv
hdl/circle_from_three_points_unit.sv
tb/tb_top.sv
